// ===== hw/rtl/skl_pkg.sv =====
package skl_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic        [63:0] key_high;
        logic        [63:0] key_middle;
        logic        [23:0] key_low;
        logic signed [31:0] value;
    } t_entry;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_POP    = 2'd2,
        OP_PRINT  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // broadcast to every cell
    typedef enum logic [2:0] {
        CM_HOLD   = 3'd0,
        CM_INSERT = 3'd1,
        CM_DELETE = 3'd2,
        CM_POP    = 3'd3,
        CM_ROTATE = 3'd4
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        t_entry     entry;
    } t_cell_cmd;

    // per-cell position info from the controller and the left neighbour
    typedef struct packed {
        logic occupied;
        logic wrap;
        logic left_lt;
    } t_cell_link;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cell_flags;

endpackage

// ===== hw/rtl/sorted_keyed_list.sv =====
// Sorted keyed list: up to CAPACITY entries held in ascending key order in
// a row of cells, each cell one entry (152-bit name key plus signed value).
//
// Request channel: a request is taken at a rising edge with start high and
// busy low. Operations are insert, delete by name, remove head and print.
// Result channel: each result sits on the o_ ports for one cycle with
// o_result_valid high; the receiver cannot stall it, so none is held.
//
// Timing: the first result of a request appears in the cycle after the
// request is taken. Insert, delete and remove head give one result each and
// a new request may follow at once: every cell compares its key with the
// request key in parallel and shifts left or right in the same edge.
// Print gives one result per entry (one if the list is empty): the row
// rotates one cell per cycle, the head cell is streamed out, after a full
// turn the row is back in order, and busy is high for the rest of a print.
//
// Reset clears the entry count and the sequencer; cell contents are not
// cleared and are only ever read below the entry count.
module sorted_keyed_list (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [63:0]        i_key_bytes_high,
    input  logic [63:0]        i_key_bytes_middle,
    input  logic [23:0]        i_key_bytes_low,
    input  logic signed [31:0] i_item_value,
    output logic               o_result_valid,
    output logic [2:0]         o_status,
    output logic [6:0]         o_occupancy,
    output logic [63:0]        o_out_key_high,
    output logic [63:0]        o_out_key_middle,
    output logic [23:0]        o_out_key_low,
    output logic signed [31:0] o_out_value,
    output logic               o_entry_present,
    output logic               o_final_result
);

    localparam int CAP   = skl_pkg::CAPACITY;
    localparam int CNT_W = skl_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_PRINT = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_left,  n_left;

    // result register
    logic                   r_valid, n_valid;
    skl_pkg::t_status       r_status, n_status;
    logic [CNT_W-1:0]       r_occ;
    skl_pkg::t_entry        r_out, n_out;
    logic                   r_present, n_present;
    logic                   r_final, n_final;

    skl_pkg::t_cell_cmd     w_cmd;
    skl_pkg::t_cell_link    w_link  [CAP];
    skl_pkg::t_cell_flags   w_flags [CAP];
    skl_pkg::t_entry        w_entry [CAP];
    skl_pkg::t_entry        w_left  [CAP];
    skl_pkg::t_entry        w_right [CAP];
    logic [CAP-1:0]         w_eq;
    logic                   w_found;
    logic                   w_accept;
    logic                   w_empty;
    logic                   w_full;

    assign busy     = (r_state == S_PRINT);
    assign w_accept = start && !busy;
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CNT_W'(CAP));
    assign w_found  = |w_eq;

    // the row of cells; neighbour links at the two ends fold back
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        assign w_link[g].occupied = (CNT_W'(g) < r_count);
        assign w_link[g].wrap     = (CNT_W'(g) == (r_count - CNT_W'(1)));
        assign w_eq[g]            = w_flags[g].eq;

        if (g == 0) begin : g_first
            assign w_link[g].left_lt = 1'b1;
            assign w_left[g]         = w_cmd.entry;
        end else begin : g_inner_l
            assign w_link[g].left_lt = w_flags[g-1].lt;
            assign w_left[g]         = w_entry[g-1];
        end

        if (g == CAP - 1) begin : g_last
            assign w_right[g] = w_entry[g];
        end else begin : g_inner_r
            assign w_right[g] = w_entry[g+1];
        end

        skl_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_link  (w_link[g]),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_head  (w_entry[0]),
            .o_entry (w_entry[g]),
            .o_flags (w_flags[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_valid     = 1'b0;
        n_status    = skl_pkg::ST_OK;
        n_out       = '0;
        n_present   = 1'b0;
        n_final     = 1'b1;
        w_cmd.mode  = skl_pkg::CM_HOLD;
        w_cmd.entry.key_high   = i_key_bytes_high;
        w_cmd.entry.key_middle = i_key_bytes_middle;
        w_cmd.entry.key_low    = i_key_bytes_low;
        w_cmd.entry.value      = i_item_value;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_valid = 1'b1;
                    unique case (skl_pkg::t_op'(i_operation))
                        skl_pkg::OP_INSERT: begin
                            // duplicate takes priority over full
                            if (w_found) begin
                                n_status = skl_pkg::ST_DUP;
                            end else if (w_full) begin
                                n_status = skl_pkg::ST_FULL;
                            end else begin
                                w_cmd.mode = skl_pkg::CM_INSERT;
                                n_count    = r_count + CNT_W'(1);
                            end
                        end
                        skl_pkg::OP_DELETE: begin
                            if (w_empty) begin
                                n_status = skl_pkg::ST_EMPTY;
                            end else if (!w_found) begin
                                n_status = skl_pkg::ST_MISSING;
                            end else begin
                                w_cmd.mode = skl_pkg::CM_DELETE;
                                n_count    = r_count - CNT_W'(1);
                            end
                        end
                        skl_pkg::OP_POP: begin
                            if (w_empty) begin
                                n_status = skl_pkg::ST_EMPTY;
                            end else begin
                                w_cmd.mode = skl_pkg::CM_POP;
                                n_count    = r_count - CNT_W'(1);
                            end
                        end
                        skl_pkg::OP_PRINT: begin
                            // empty list: single result with no entry
                            if (!w_empty) begin
                                w_cmd.mode = skl_pkg::CM_ROTATE;
                                n_out      = w_entry[0];
                                n_present  = 1'b1;
                                n_final    = (r_count == CNT_W'(1));
                                n_left     = r_count - CNT_W'(1);
                                if (r_count != CNT_W'(1)) begin
                                    n_state = S_PRINT;
                                end
                            end
                        end
                        default: begin
                            n_status = skl_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_PRINT: begin
                // stream the head, rotate the row by one cell
                n_valid    = 1'b1;
                w_cmd.mode = skl_pkg::CM_ROTATE;
                n_out      = w_entry[0];
                n_present  = 1'b1;
                n_final    = (r_left == CNT_W'(1));
                n_left     = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_occ     <= n_count;
        r_out     <= n_out;
        r_present <= n_present;
        r_final   <= n_final;
    end

    assign o_result_valid   = r_valid;
    assign o_status         = r_status;
    assign o_occupancy      = 7'(r_occ);
    assign o_out_key_high   = r_out.key_high;
    assign o_out_key_middle = r_out.key_middle;
    assign o_out_key_low    = r_out.key_low;
    assign o_out_value      = r_out.value;
    assign o_entry_present  = r_present;
    assign o_final_result   = r_final;

endmodule

// ===== hw/rtl/skl_cell.sv =====
module skl_cell (
    input  logic                i_clk,
    input  skl_pkg::t_cell_cmd  i_cmd,
    input  skl_pkg::t_cell_link i_link,
    input  skl_pkg::t_entry     i_left,
    input  skl_pkg::t_entry     i_right,
    input  skl_pkg::t_entry     i_head,
    output skl_pkg::t_entry     o_entry,
    output skl_pkg::t_cell_flags o_flags
);

    skl_pkg::t_entry r_entry;
    skl_pkg::t_entry n_entry;
    logic [151:0]    w_stored;
    logic [151:0]    w_key;

    assign w_stored = {r_entry.key_high, r_entry.key_middle, r_entry.key_low};
    assign w_key    = {i_cmd.entry.key_high, i_cmd.entry.key_middle, i_cmd.entry.key_low};

    // stored key below the request key: cell stays put on insert/delete
    assign o_flags.lt = i_link.occupied && (w_stored < w_key);
    assign o_flags.eq = i_link.occupied && (w_stored == w_key);
    assign o_entry    = r_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.mode)
            skl_pkg::CM_HOLD: begin
                n_entry = r_entry;
            end
            skl_pkg::CM_INSERT: begin
                if (!o_flags.lt) begin
                    n_entry = i_link.left_lt ? i_cmd.entry : i_left;
                end
            end
            skl_pkg::CM_DELETE: begin
                if (!o_flags.lt) begin
                    n_entry = i_right;
                end
            end
            skl_pkg::CM_POP: begin
                n_entry = i_right;
            end
            skl_pkg::CM_ROTATE: begin
                n_entry = i_link.wrap ? i_head : i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
